### hdl/mpd_pkg.sv
// ----------------------------------------------------------------------------
// mpd_pkg
// Types, constants and codes shared by the program stream demultiplexer.
// ----------------------------------------------------------------------------
package mpd_pkg;

  localparam int PACK_HEADER_BYTES   = 20;
  localparam int SYSTEM_HEADER_BYTES = 18;
  localparam int PES_HEADER_BYTES    = 14;

  localparam int IDX_W = $clog2(PACK_HEADER_BYTES + 1);
  localparam int CNT_W = 24;
  localparam int LEN_W = 16;

  localparam int PES_MIN_LEN  = 8;
  localparam int LEN_FIELD_END = 6;

  localparam logic [7:0] ID_PACK  = 8'hBA;
  localparam logic [7:0] ID_SYS   = 8'hBB;
  localparam logic [7:0] ID_MAP   = 8'hBC;
  localparam logic [7:0] ID_VIDEO = 8'hE0;
  localparam logic [7:0] ID_AUDIO = 8'hC0;

  localparam logic [7:0] PACK_START [4] = '{8'h00, 8'h00, 8'h01, ID_PACK};

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_FIRST,
    PH_HEAD,
    PH_SKIP,
    PH_PAYLOAD
  } phase_t;

  typedef enum logic [2:0] {
    ST_PAYLOAD   = 3'd0,
    ST_DONE      = 3'd1,
    ST_BAD_PACK  = 3'd2,
    ST_NO_PREFIX = 3'd3,
    ST_BAD_ID    = 3'd4,
    ST_BAD_LEN   = 3'd5
  } status_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       first_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [2:0] status;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic      valid;
    out_item_t item;
  } result_t;

endpackage

### hdl/mpeg_ps_demultiplexer.sv
// ----------------------------------------------------------------------------
// mpeg_ps_demultiplexer
// Program stream demultiplexer: strips pack, system, map and PES headers and
// passes on the elementary stream payload bytes.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready/in_data) takes one stream byte per item;
// first_byte set restarts the parse with that byte as byte 0 of a packet.
// Output channel (out_valid/out_ready/out_data) gives zero or one result per
// input item: a payload byte (status 0) or a done/error code with last set.
// An accepted item waits in the input register until the result register is
// free, is then parsed, and its result is registered in the result register.
// Throughput: one byte per cycle while no result waits on out_ready; each byte
// only steps the phase and the size counters, all inside the single parse stage.
// Reset (rst, synchronous): both registers empty, parser idle; bytes are
// ignored until one arrives with first_byte set.
// Stall: while a result waits on out_ready, a byte that is already held is
// parsed only when the result register frees, and one more byte can be taken
// into the input register; in_ready drops once both are full.
// ----------------------------------------------------------------------------
module mpeg_ps_demultiplexer (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  mpd_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output mpd_pkg::out_item_t out_data
);

  logic              hold_valid;
  mpd_pkg::in_item_t hold_item;
  logic              out_free;
  logic              step;
  mpd_pkg::result_t  res;

  assign step = hold_valid && out_free;

  mpd_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .take       (step),
    .hold_valid (hold_valid),
    .hold_item  (hold_item)
  );

  mpd_parser u_parse (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .item (hold_item),
    .res  (res)
  );

  mpd_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .res       (res),
    .out_free  (out_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

### hdl/mpd_in_stage.sv
// ----------------------------------------------------------------------------
// mpd_in_stage
// Input register: holds one accepted item until the parser consumes it.
// ----------------------------------------------------------------------------
module mpd_in_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  mpd_pkg::in_item_t in_data,
  input  logic              take,
  output logic              hold_valid,
  output mpd_pkg::in_item_t hold_item
);

  assign in_ready = !hold_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_item <= in_data;
    end
  end

endmodule

### hdl/mpd_parser.sv
// ----------------------------------------------------------------------------
// mpd_parser
// Header walker and payload counter; one byte per step.
// ----------------------------------------------------------------------------
module mpd_parser (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  mpd_pkg::in_item_t item,
  output mpd_pkg::result_t  res
);

  localparam int CW = mpd_pkg::CNT_W;
  localparam int LW = mpd_pkg::LEN_W;
  localparam int IW = mpd_pkg::IDX_W;

  mpd_pkg::phase_t phase, phase_next;
  logic [IW-1:0]   idx, idx_next;
  logic [LW-1:0]   skip_left, skip_left_next;
  logic [LW-1:0]   payload_left, payload_left_next;
  logic [CW-1:0]   pkt_left, pkt_left_next;
  logic [CW-1:0]   frm_left, frm_left_next;
  logic [7:0]      cur_id, cur_id_next;
  logic [7:0]      len_hi, len_hi_next;

  logic [7:0]      b;
  logic            fb;
  mpd_pkg::phase_t e_phase;
  logic [IW-1:0]   e_idx;
  logic [CW-1:0]   e_pkt, e_frm;
  logic [CW-1:0]   first_pkt, first_frm;
  logic [CW-1:0]   pkt_dec, frm_dec;
  logic [LW-1:0]   pl_dec, skip_dec, head_len;
  logic            start_bad, first_end, first_stop;
  logic            prefix_bad, id_bad, sid_pes;
  logic            unit_stop, pay_stop;

  assign b  = item.in_byte;
  assign fb = item.first_byte;

  assign e_phase = fb ? mpd_pkg::PH_FIRST : phase;
  assign e_idx   = fb ? '0 : idx;
  assign e_pkt   = fb ? '0 : pkt_left;
  assign e_frm   = fb ? '0 : frm_left;

  assign start_bad = (e_idx < IW'(4)) && (b != mpd_pkg::PACK_START[e_idx[1:0]]);
  assign first_pkt = (e_idx >= IW'(mpd_pkg::PACK_HEADER_BYTES - 6) &&
                      e_idx <  IW'(mpd_pkg::PACK_HEADER_BYTES - 3)) ?
                     {e_pkt[CW-9:0], b} : e_pkt;
  assign first_frm = (e_idx >= IW'(mpd_pkg::PACK_HEADER_BYTES - 3)) ?
                     {e_frm[CW-9:0], b} : e_frm;
  assign first_end  = (e_idx == IW'(mpd_pkg::PACK_HEADER_BYTES - 1));
  assign first_stop = (first_frm == '0) ||
                      (first_pkt <= CW'(mpd_pkg::PACK_HEADER_BYTES));

  assign pkt_dec  = (e_pkt == '0) ? '0 : e_pkt - CW'(1);
  assign frm_dec  = (e_frm == '0) ? '0 : e_frm - CW'(1);
  assign pl_dec   = (payload_left == '0) ? '0 : payload_left - LW'(1);
  assign skip_dec = (skip_left == '0) ? '0 : skip_left - LW'(1);
  assign head_len = {len_hi, b};

  assign prefix_bad = (e_idx < IW'(2)) ? (b != 8'h00) : (b != 8'h01);
  assign id_bad     = !(b == mpd_pkg::ID_PACK || b == mpd_pkg::ID_SYS ||
                        b == mpd_pkg::ID_MAP || b == mpd_pkg::ID_VIDEO ||
                        b == mpd_pkg::ID_AUDIO);
  assign sid_pes    = (cur_id == mpd_pkg::ID_VIDEO) ||
                      (cur_id == mpd_pkg::ID_AUDIO);
  assign unit_stop  = (pkt_dec == '0) || (e_frm == '0);
  assign pay_stop   = (pkt_dec == '0) || (frm_dec == '0);

  // next state
  always_comb begin
    phase_next        = phase;
    idx_next          = idx;
    skip_left_next    = skip_left;
    payload_left_next = payload_left;
    pkt_left_next     = pkt_left;
    frm_left_next     = frm_left;
    cur_id_next       = cur_id;
    len_hi_next       = len_hi;
    if (step) begin
      phase_next    = e_phase;
      idx_next      = e_idx;
      pkt_left_next = e_pkt;
      frm_left_next = e_frm;
      unique case (e_phase)
        mpd_pkg::PH_IDLE: begin
        end
        mpd_pkg::PH_FIRST: begin
          if (start_bad) begin
            phase_next = mpd_pkg::PH_IDLE;
          end else begin
            pkt_left_next = first_pkt;
            frm_left_next = first_frm;
            idx_next      = e_idx + IW'(1);
            if (first_end) begin
              if (first_stop) begin
                phase_next = mpd_pkg::PH_IDLE;
              end else begin
                pkt_left_next = first_pkt - CW'(mpd_pkg::PACK_HEADER_BYTES);
                phase_next    = mpd_pkg::PH_HEAD;
                idx_next      = '0;
              end
            end
          end
        end
        mpd_pkg::PH_HEAD: begin
          pkt_left_next = pkt_dec;
          idx_next      = e_idx + IW'(1);
          if (e_idx <= IW'(2)) begin
            if (prefix_bad) begin
              phase_next = mpd_pkg::PH_IDLE;
            end
          end else if (e_idx == IW'(3)) begin
            cur_id_next       = b;
            payload_left_next = '0;
            if (b == mpd_pkg::ID_PACK) begin
              skip_left_next = LW'(mpd_pkg::PACK_HEADER_BYTES - 4);
              phase_next     = mpd_pkg::PH_SKIP;
            end else if (b == mpd_pkg::ID_SYS) begin
              skip_left_next = LW'(mpd_pkg::SYSTEM_HEADER_BYTES - 4);
              phase_next     = mpd_pkg::PH_SKIP;
            end else if (id_bad) begin
              phase_next = mpd_pkg::PH_IDLE;
            end
          end else if (e_idx == IW'(4)) begin
            len_hi_next = b;
          end else if (cur_id == mpd_pkg::ID_MAP) begin
            skip_left_next = head_len;
            if (head_len != '0) begin
              phase_next = mpd_pkg::PH_SKIP;
            end else if (unit_stop) begin
              phase_next = mpd_pkg::PH_IDLE;
            end else begin
              idx_next = '0;
            end
          end else if (head_len < LW'(mpd_pkg::PES_MIN_LEN)) begin
            phase_next = mpd_pkg::PH_IDLE;
          end else begin
            payload_left_next = head_len - LW'(mpd_pkg::PES_MIN_LEN);
            skip_left_next    = LW'(mpd_pkg::PES_HEADER_BYTES - mpd_pkg::LEN_FIELD_END);
            phase_next        = mpd_pkg::PH_SKIP;
          end
        end
        mpd_pkg::PH_SKIP: begin
          pkt_left_next  = pkt_dec;
          skip_left_next = skip_dec;
          if (skip_dec == '0) begin
            if (sid_pes && payload_left != '0) begin
              phase_next = mpd_pkg::PH_PAYLOAD;
            end else if (unit_stop) begin
              phase_next = mpd_pkg::PH_IDLE;
            end else begin
              phase_next = mpd_pkg::PH_HEAD;
              idx_next   = '0;
            end
          end
        end
        mpd_pkg::PH_PAYLOAD: begin
          pkt_left_next     = pkt_dec;
          frm_left_next     = frm_dec;
          payload_left_next = pl_dec;
          if (pl_dec == '0) begin
            if (pay_stop) begin
              phase_next = mpd_pkg::PH_IDLE;
            end else begin
              phase_next = mpd_pkg::PH_HEAD;
              idx_next   = '0;
            end
          end
        end
        default: begin
          phase_next = mpd_pkg::PH_IDLE;
        end
      endcase
    end
  end

  // result
  always_comb begin
    res = '0;
    if (step) begin
      unique case (e_phase)
        mpd_pkg::PH_IDLE: begin
        end
        mpd_pkg::PH_FIRST: begin
          if (start_bad) begin
            res.valid       = 1'b1;
            res.item.status = mpd_pkg::ST_BAD_PACK;
            res.item.last   = 1'b1;
          end else if (first_end && first_stop) begin
            res.valid       = 1'b1;
            res.item.status = mpd_pkg::ST_DONE;
            res.item.last   = 1'b1;
          end
        end
        mpd_pkg::PH_HEAD: begin
          if (e_idx <= IW'(2)) begin
            if (prefix_bad) begin
              res.valid       = 1'b1;
              res.item.status = mpd_pkg::ST_NO_PREFIX;
              res.item.last   = 1'b1;
            end
          end else if (e_idx == IW'(3)) begin
            if (id_bad) begin
              res.valid       = 1'b1;
              res.item.status = mpd_pkg::ST_BAD_ID;
              res.item.last   = 1'b1;
            end
          end else if (e_idx == IW'(4)) begin
          end else if (cur_id == mpd_pkg::ID_MAP) begin
            if (head_len == '0 && unit_stop) begin
              res.valid       = 1'b1;
              res.item.status = mpd_pkg::ST_DONE;
              res.item.last   = 1'b1;
            end
          end else if (head_len < LW'(mpd_pkg::PES_MIN_LEN)) begin
            res.valid       = 1'b1;
            res.item.status = mpd_pkg::ST_BAD_LEN;
            res.item.last   = 1'b1;
          end
        end
        mpd_pkg::PH_SKIP: begin
          if (skip_dec == '0 && !(sid_pes && payload_left != '0) && unit_stop) begin
            res.valid       = 1'b1;
            res.item.status = mpd_pkg::ST_DONE;
            res.item.last   = 1'b1;
          end
        end
        mpd_pkg::PH_PAYLOAD: begin
          res.valid         = 1'b1;
          res.item.out_byte = b;
          res.item.status   = mpd_pkg::ST_PAYLOAD;
          res.item.last     = (pl_dec == '0) && pay_stop;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= mpd_pkg::PH_IDLE;
      idx          <= '0;
      skip_left    <= '0;
      payload_left <= '0;
      pkt_left     <= '0;
      frm_left     <= '0;
      cur_id       <= '0;
      len_hi       <= '0;
    end else begin
      phase        <= phase_next;
      idx          <= idx_next;
      skip_left    <= skip_left_next;
      payload_left <= payload_left_next;
      pkt_left     <= pkt_left_next;
      frm_left     <= frm_left_next;
      cur_id       <= cur_id_next;
      len_hi       <= len_hi_next;
    end
  end

endmodule

### hdl/mpd_out_stage.sv
// ----------------------------------------------------------------------------
// mpd_out_stage
// Result register: holds one result until the receiver takes it.
// ----------------------------------------------------------------------------
module mpd_out_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  mpd_pkg::result_t   res,
  output logic               out_free,
  output logic               out_valid,
  input  logic               out_ready,
  output mpd_pkg::out_item_t out_data
);

  logic load;

  assign out_free = !out_valid || out_ready;
  assign load     = step && res.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= res.item;
    end
  end

endmodule

### hdl/mpd_checker.sv
// ----------------------------------------------------------------------------
// mpd_checker
// Port-level checks for the program stream demultiplexer.
// ----------------------------------------------------------------------------
module mpd_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input mpd_pkg::out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output item changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.status <= mpd_pkg::ST_BAD_LEN)
    else $error("undefined status code");

  a_end_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status != mpd_pkg::ST_PAYLOAD |->
      out_data.last && out_data.out_byte == 8'h00)
    else $error("done or error item without last or with data");

  a_in_stall: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without a waiting result");

endmodule

bind mpeg_ps_demultiplexer mpd_checker u_chk (.*);

### bench/mpeg_ps_demultiplexer_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mpeg_ps_demultiplexer_tb
// Drives program stream packets byte by byte into the demultiplexer and checks
// every payload byte and done/error code against a parse model kept in step
// with the accepted items. Directed packets cover the header kinds, size ends
// and each error; a random stream of mostly well-formed packets follows, with
// bursty input, output stalls and one long output hold-off.
// ----------------------------------------------------------------------------
module mpeg_ps_demultiplexer_tb;

  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 8;
  localparam int RANDOM_ITEMS = 450;
  localparam int MAX_REPORTS  = 100;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  mpd_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  mpd_pkg::out_item_t out_data;

  mpeg_ps_demultiplexer dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // parse model state
  mpd_pkg::phase_t ps_phase = mpd_pkg::PH_IDLE;
  logic [16:0] ps_hdr_idx = '0;
  logic [16:0] ps_skip_left = '0;
  logic [15:0] ps_payload_left = '0;
  logic [23:0] ps_packet_left = '0;
  logic [23:0] ps_frame_left = '0;
  logic [7:0]  ps_cur_id = '0;
  logic [7:0]  ps_len_hi = '0;

  mpd_pkg::out_item_t expected_results[$];
  logic [7:0]  pkt_bytes[$];

  int          mismatches = 0;
  int          bytes_sent = 0;
  bit          tx_gaps_on = 1'b1;
  int          tx_burst_left = 0;
  int          holds_asked = 0;
  int          holds_done = 0;
  int          hold_left = 0;
  logic [15:0] rx_tick = '0;

  // ---------------------------------------------------------------- model
  function automatic logic [23:0] sat_sub(logic [23:0] v, int unsigned n);
    return (v > n) ? 24'(v - n) : 24'd0;
  endfunction

  function automatic void push_result(logic [7:0] b, mpd_pkg::status_t st, logic lst);
    mpd_pkg::out_item_t r;
    r.out_byte = b;
    r.status   = st;
    r.last     = lst;
    expected_results.push_back(r);
  endfunction

  function automatic void abort_parse(mpd_pkg::status_t st);
    ps_phase = mpd_pkg::PH_IDLE;
    push_result(8'h00, st, 1'b1);
  endfunction

  // end of a header or payload: stop if either size ran out
  function automatic void close_unit();
    if (ps_packet_left == 0 || ps_frame_left == 0) begin
      ps_phase = mpd_pkg::PH_IDLE;
      push_result(8'h00, mpd_pkg::ST_DONE, 1'b1);
    end else begin
      ps_phase = mpd_pkg::PH_HEAD;
      ps_hdr_idx = '0;
    end
  endfunction

  function automatic void predict_byte(logic [7:0] b, logic fb);
    logic [16:0] idx;
    logic [15:0] len;
    if (fb) begin
      ps_phase        = mpd_pkg::PH_FIRST;
      ps_hdr_idx      = '0;
      ps_skip_left    = '0;
      ps_payload_left = '0;
      ps_packet_left  = '0;
      ps_frame_left   = '0;
      ps_cur_id       = '0;
      ps_len_hi       = '0;
    end
    idx = ps_hdr_idx;
    case (ps_phase)
      mpd_pkg::PH_FIRST: begin
        if (idx < 4 && b != mpd_pkg::PACK_START[idx[1:0]]) begin
          abort_parse(mpd_pkg::ST_BAD_PACK);
        end else begin
          if (idx >= mpd_pkg::PACK_HEADER_BYTES - 6 && idx < mpd_pkg::PACK_HEADER_BYTES - 3)
            ps_packet_left = {ps_packet_left[15:0], b};
          else if (idx >= mpd_pkg::PACK_HEADER_BYTES - 3)
            ps_frame_left = {ps_frame_left[15:0], b};
          ps_hdr_idx = idx + 17'd1;
          if (ps_hdr_idx == mpd_pkg::PACK_HEADER_BYTES) begin
            if (ps_packet_left == 0 || ps_frame_left == 0) begin
              abort_parse(mpd_pkg::ST_DONE);
            end else begin
              ps_packet_left = sat_sub(ps_packet_left, mpd_pkg::PACK_HEADER_BYTES);
              close_unit();
            end
          end
        end
      end
      mpd_pkg::PH_HEAD: begin
        ps_packet_left = sat_sub(ps_packet_left, 1);
        ps_hdr_idx = idx + 17'd1;
        if (idx < 2) begin
          if (b != 8'h00) abort_parse(mpd_pkg::ST_NO_PREFIX);
        end else if (idx == 2) begin
          if (b != 8'h01) abort_parse(mpd_pkg::ST_NO_PREFIX);
        end else if (idx == 3) begin
          ps_cur_id = b;
          ps_payload_left = '0;
          if (b == mpd_pkg::ID_PACK) begin
            ps_skip_left = 17'(mpd_pkg::PACK_HEADER_BYTES - 4);
            ps_phase = mpd_pkg::PH_SKIP;
          end else if (b == mpd_pkg::ID_SYS) begin
            ps_skip_left = 17'(mpd_pkg::SYSTEM_HEADER_BYTES - 4);
            ps_phase = mpd_pkg::PH_SKIP;
          end else if (b != mpd_pkg::ID_MAP && b != mpd_pkg::ID_VIDEO &&
                       b != mpd_pkg::ID_AUDIO) begin
            abort_parse(mpd_pkg::ST_BAD_ID);
          end
        end else if (idx == 4) begin
          ps_len_hi = b;
        end else begin
          len = {ps_len_hi, b};
          if (ps_cur_id == mpd_pkg::ID_MAP) begin
            ps_skip_left = 17'(len);
            if (len == 0) close_unit();
            else ps_phase = mpd_pkg::PH_SKIP;
          end else if (len < mpd_pkg::PES_MIN_LEN) begin
            abort_parse(mpd_pkg::ST_BAD_LEN);
          end else begin
            ps_payload_left = 16'(len - mpd_pkg::PES_MIN_LEN);
            ps_skip_left = 17'(mpd_pkg::PES_HEADER_BYTES - mpd_pkg::LEN_FIELD_END);
            ps_phase = mpd_pkg::PH_SKIP;
          end
        end
      end
      mpd_pkg::PH_SKIP: begin
        ps_packet_left = sat_sub(ps_packet_left, 1);
        ps_skip_left = 17'(sat_sub(24'(ps_skip_left), 1));
        if (ps_skip_left == 0) begin
          if ((ps_cur_id == mpd_pkg::ID_VIDEO || ps_cur_id == mpd_pkg::ID_AUDIO) &&
              ps_payload_left != 0)
            ps_phase = mpd_pkg::PH_PAYLOAD;
          else
            close_unit();
        end
      end
      mpd_pkg::PH_PAYLOAD: begin
        ps_packet_left = sat_sub(ps_packet_left, 1);
        ps_frame_left = sat_sub(ps_frame_left, 1);
        ps_payload_left = 16'(sat_sub(24'(ps_payload_left), 1));
        if (ps_payload_left != 0) begin
          push_result(b, mpd_pkg::ST_PAYLOAD, 1'b0);
        end else if (ps_packet_left == 0 || ps_frame_left == 0) begin
          ps_phase = mpd_pkg::PH_IDLE;
          push_result(b, mpd_pkg::ST_PAYLOAD, 1'b1);
        end else begin
          ps_phase = mpd_pkg::PH_HEAD;
          ps_hdr_idx = '0;
          push_result(b, mpd_pkg::ST_PAYLOAD, 1'b0);
        end
      end
      default: ps_phase = mpd_pkg::PH_IDLE;
    endcase
  endfunction

  // ---------------------------------------------------------------- checking
  task automatic report_mismatch(string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("%0t ns: MISMATCH %s", $time, msg);
  endtask

  task automatic check_result(mpd_pkg::out_item_t got);
    mpd_pkg::out_item_t want;
    if (expected_results.size() == 0) begin
      report_mismatch($sformatf("result with none pending: byte %02h status %0d last %0d",
                                got.out_byte, got.status, got.last));
    end else begin
      want = expected_results.pop_front();
      if (got.out_byte !== want.out_byte)
        report_mismatch($sformatf("out_byte got %02h want %02h", got.out_byte, want.out_byte));
      if (got.status !== want.status)
        report_mismatch($sformatf("status got %0d want %0d", got.status, want.status));
      if (got.last !== want.last)
        report_mismatch($sformatf("last got %0d want %0d", got.last, want.last));
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) check_result(out_data);
  end

  // ---------------------------------------------------------------- receiver
  always @(posedge clk) begin
    rx_tick <= rx_tick + 1'b1;
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (holds_done != holds_asked) begin
      out_ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      holds_done <= holds_done + 1;
    end else begin
      case (rx_tick[9:7])
        3'd0, 3'd1: out_ready <= 1'b1;
        3'd2, 3'd3: out_ready <= ($urandom_range(0, 3) != 0);
        3'd4:       out_ready <= ($urandom_range(0, 3) == 0);
        3'd5:       out_ready <= (rx_tick[2:0] != 3'd0);
        default:    out_ready <= 1'($urandom_range(0, 1));
      endcase
    end
  end

  // ---------------------------------------------------------------- sender
  task automatic send_byte(logic [7:0] b, logic fb);
    mpd_pkg::in_item_t item;
    if (tx_gaps_on && tx_burst_left == 0) begin
      tx_burst_left = int'($urandom_range(1, 24));
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    if (tx_burst_left != 0) tx_burst_left--;
    item.in_byte = b;
    item.first_byte = fb;
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (!in_ready);
    predict_byte(b, fb);
    bytes_sent++;
  endtask

  task automatic tx_idle();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    tx_idle();
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic send_packet(logic flag_first);
    foreach (pkt_bytes[i]) send_byte(pkt_bytes[i], flag_first && i == 0);
    pkt_bytes.delete();
  endtask

  // ---------------------------------------------------------------- packet build
  function automatic void put_rand(int n);
    repeat (n) pkt_bytes.push_back(8'($urandom_range(0, 255)));
  endfunction

  function automatic void put_start_code(logic [7:0] id);
    pkt_bytes.push_back(8'h00);
    pkt_bytes.push_back(8'h00);
    pkt_bytes.push_back(8'h01);
    pkt_bytes.push_back(id);
  endfunction

  // sizes are left zero here and filled in by set_sizes
  function automatic void put_pack_header();
    put_start_code(mpd_pkg::ID_PACK);
    put_rand(mpd_pkg::PACK_HEADER_BYTES - 10);
    repeat (6) pkt_bytes.push_back(8'h00);
  endfunction

  function automatic void set_sizes(logic [23:0] psize, logic [23:0] fsize);
    for (int k = 0; k < 3; k++) begin
      pkt_bytes[mpd_pkg::PACK_HEADER_BYTES - 6 + k] = psize[23 - 8*k -: 8];
      pkt_bytes[mpd_pkg::PACK_HEADER_BYTES - 3 + k] = fsize[23 - 8*k -: 8];
    end
  endfunction

  function automatic void put_fixed_header(logic [7:0] id, int n);
    put_start_code(id);
    put_rand(n - 4);
  endfunction

  function automatic void put_map(logic [15:0] len);
    put_start_code(mpd_pkg::ID_MAP);
    pkt_bytes.push_back(len[15:8]);
    pkt_bytes.push_back(len[7:0]);
    put_rand(int'(len));
  endfunction

  function automatic void put_pes(logic [7:0] id, logic [15:0] len);
    put_start_code(id);
    pkt_bytes.push_back(len[15:8]);
    pkt_bytes.push_back(len[7:0]);
    put_rand(mpd_pkg::PES_HEADER_BYTES - mpd_pkg::LEN_FIELD_END);
    if (len > mpd_pkg::PES_MIN_LEN) put_rand(int'(len) - mpd_pkg::PES_MIN_LEN);
  endfunction

  function automatic void trim_to(int n);
    while (pkt_bytes.size() > n) pkt_bytes.delete(pkt_bytes.size() - 1);
  endfunction

  // ---------------------------------------------------------------- tests
  task automatic test_idle_and_restart();
    // nothing started yet: a whole pack start code without the flag is ignored
    put_start_code(mpd_pkg::ID_PACK);
    put_rand(6);
    send_packet(1'b0);
    // restart in the middle of a payload
    put_pack_header();
    put_pes(mpd_pkg::ID_VIDEO, 16'd30);
    set_sizes(24'hFFFFFF, 24'hFFFFFF);
    trim_to(mpd_pkg::PACK_HEADER_BYTES + mpd_pkg::PES_HEADER_BYTES + 5);
    send_packet(1'b1);
    // restart inside the first pack header
    put_pack_header();
    trim_to(7);
    send_packet(1'b1);
    put_pack_header();
    put_pes(mpd_pkg::ID_AUDIO, 16'd11);
    set_sizes(24'(pkt_bytes.size()), 24'hFFFFFF);
    send_packet(1'b1);
    wait_drained();
  endtask

  task automatic test_well_formed();
    put_pack_header();
    put_fixed_header(mpd_pkg::ID_SYS, mpd_pkg::SYSTEM_HEADER_BYTES);
    put_map(16'd3);
    put_map(16'd0);
    put_pes(mpd_pkg::ID_VIDEO, 16'd12);
    pkt_bytes[$] = 8'hFF;
    pkt_bytes[$ - 1] = 8'h00;
    put_pes(mpd_pkg::ID_AUDIO, 16'd8);
    put_fixed_header(mpd_pkg::ID_PACK, mpd_pkg::PACK_HEADER_BYTES);
    put_pes(mpd_pkg::ID_AUDIO, 16'd10);
    set_sizes(24'(pkt_bytes.size()), 24'd6);
    send_packet(1'b1);
    // packet size runs out on a header
    put_pack_header();
    put_fixed_header(mpd_pkg::ID_SYS, mpd_pkg::SYSTEM_HEADER_BYTES);
    set_sizes(24'(pkt_bytes.size()), 24'hFFFFFF);
    send_packet(1'b1);
    // frame size runs out inside a payload and stays at zero
    put_pack_header();
    put_pes(mpd_pkg::ID_VIDEO, 16'd20);
    put_pes(mpd_pkg::ID_VIDEO, 16'd9);
    set_sizes(24'hFFFFFF, 24'd5);
    send_packet(1'b1);
  endtask

  task automatic test_zero_sizes();
    put_pack_header();
    put_pes(mpd_pkg::ID_VIDEO, 16'd10);
    set_sizes(24'd0, 24'd100);
    send_packet(1'b1);
    put_pack_header();
    put_pes(mpd_pkg::ID_VIDEO, 16'd10);
    set_sizes(24'd100, 24'd0);
    send_packet(1'b1);
    // packet size shorter than the pack header itself
    put_pack_header();
    put_pes(mpd_pkg::ID_AUDIO, 16'd10);
    set_sizes(24'd5, 24'd1);
    send_packet(1'b1);
  endtask

  task automatic test_bad_pack_header();
    for (int k = 0; k < 4; k++) begin
      put_pack_header();
      pkt_bytes[k] = pkt_bytes[k] ^ 8'h80;
      trim_to(8);
      send_packet(1'b1);
    end
  endtask

  task automatic test_missing_prefix();
    for (int k = 0; k < 3; k++) begin
      put_pack_header();
      put_fixed_header(mpd_pkg::ID_SYS, mpd_pkg::SYSTEM_HEADER_BYTES);
      pkt_bytes[mpd_pkg::PACK_HEADER_BYTES + k] =
        pkt_bytes[mpd_pkg::PACK_HEADER_BYTES + k] ^ 8'h01;
      set_sizes(24'hFFFFFF, 24'hFFFFFF);
      send_packet(1'b1);
    end
  endtask

  task automatic test_unknown_id();
    logic [7:0] ids[4] = '{8'hBD, 8'h00, 8'hFF, 8'hE1};
    foreach (ids[k]) begin
      put_pack_header();
      put_start_code(ids[k]);
      put_rand(4);
      set_sizes(24'hFFFFFF, 24'hFFFFFF);
      send_packet(1'b1);
    end
  endtask

  task automatic test_short_pes_length();
    put_pack_header();
    put_pes(mpd_pkg::ID_VIDEO, 16'd0);
    set_sizes(24'hFFFFFF, 24'hFFFFFF);
    send_packet(1'b1);
    put_pack_header();
    put_pes(mpd_pkg::ID_AUDIO, 16'd7);
    set_sizes(24'hFFFFFF, 24'hFFFFFF);
    send_packet(1'b1);
  endtask

  task automatic test_long_length();
    // largest PES length; cut off by the next packet
    put_pack_header();
    put_start_code(mpd_pkg::ID_VIDEO);
    pkt_bytes.push_back(8'hFF);
    pkt_bytes.push_back(8'hFF);
    put_rand(mpd_pkg::PES_HEADER_BYTES - mpd_pkg::LEN_FIELD_END + 40);
    set_sizes(24'hFFFFFF, 24'hFFFFFF);
    send_packet(1'b1);
    put_pack_header();
    put_map(16'h0102);
    put_pes(mpd_pkg::ID_AUDIO, 16'd9);
    set_sizes(24'h800000, 24'h000001);
    send_packet(1'b1);
    wait_drained();
  endtask

  task automatic test_receiver_hold();
    tx_gaps_on = 1'b0;
    holds_asked++;
    put_pack_header();
    put_pes(mpd_pkg::ID_VIDEO, 16'd80);
    put_pes(mpd_pkg::ID_AUDIO, 16'd20);
    set_sizes(24'(pkt_bytes.size()), 24'hFFFFFF);
    send_packet(1'b1);
    wait_drained();
    tx_gaps_on = 1'b1;
  endtask

  task automatic test_random_stream();
    int          first_count;
    int          units;
    int          pay;
    int          total;
    int          idx;
    logic [15:0] len;
    logic [23:0] psize;
    logic [23:0] fsize;
    first_count = bytes_sent;
    while (bytes_sent - first_count < RANDOM_ITEMS) begin
      tx_gaps_on = ($urandom_range(0, 3) != 0);
      pay = 0;
      put_pack_header();
      units = int'($urandom_range(0, 4));
      repeat (units) begin
        case ($urandom_range(0, 9))
          0: put_fixed_header(mpd_pkg::ID_PACK, mpd_pkg::PACK_HEADER_BYTES);
          1: put_fixed_header(mpd_pkg::ID_SYS, mpd_pkg::SYSTEM_HEADER_BYTES);
          2: begin
            if ($urandom_range(0, 19) == 0) len = 16'($urandom_range(13, 300));
            else len = 16'($urandom_range(0, 12));
            put_map(len);
          end
          default: begin
            if ($urandom_range(0, 4) == 0) len = 16'($urandom_range(41, 300));
            else len = 16'($urandom_range(8, 40));
            put_pes($urandom_range(0, 1) ? mpd_pkg::ID_VIDEO : mpd_pkg::ID_AUDIO, len);
            pay += int'(len) - mpd_pkg::PES_MIN_LEN;
          end
        endcase
      end
      total = pkt_bytes.size();
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: psize = 24'(total);
        6:                psize = 24'($urandom_range(1, total));
        7:                psize = 24'(total + int'($urandom_range(1, 50)));
        8:                psize = 24'hFFFFFF;
        default:          psize = 24'($urandom_range(0, 30));
      endcase
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: fsize = (pay != 0) ? 24'(pay) : 24'($urandom_range(1, 24'hFFFFFF));
        6, 7:             fsize = 24'($urandom_range(1, pay + 5));
        8:                fsize = 24'hFFFFFF;
        default:          fsize = 24'($urandom);
      endcase
      set_sizes(psize, fsize);
      case ($urandom_range(0, 19))
        0: begin
          idx = int'($urandom_range(0, pkt_bytes.size() - 1));
          pkt_bytes[idx] = pkt_bytes[idx] ^ (8'h01 << $urandom_range(0, 7));
        end
        1: trim_to(int'($urandom_range(1, pkt_bytes.size() - 1)));
        2: pkt_bytes.insert(int'($urandom_range(1, pkt_bytes.size() - 1)),
                            8'($urandom_range(0, 255)));
        3: begin
          put_start_code($urandom_range(0, 1) ? mpd_pkg::ID_VIDEO : mpd_pkg::ID_AUDIO);
          pkt_bytes.push_back(8'($urandom_range(8'h80, 8'hFF)));
          pkt_bytes.push_back(8'($urandom_range(0, 255)));
          put_rand(int'($urandom_range(8, 30)));
        end
        default: ;
      endcase
      send_packet(1'b1);
      if ($urandom_range(0, 9) == 0) begin
        put_rand(int'($urandom_range(1, 8)));
        send_packet(1'b0);
      end
      if ($urandom_range(0, 29) == 0) wait_drained();
    end
    tx_gaps_on = 1'b1;
  endtask

  // ---------------------------------------------------------------- sequence
  initial begin
    int waited;
    waited = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_idle_and_restart();
    test_well_formed();
    test_zero_sizes();
    test_bad_pack_header();
    test_missing_prefix();
    test_unknown_id();
    test_short_pes_length();
    test_long_length();
    test_receiver_hold();
    test_random_stream();
    tx_idle();
    while (expected_results.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

### sim.f
hdl/mpd_pkg.sv
hdl/mpd_in_stage.sv
hdl/mpd_parser.sv
hdl/mpd_out_stage.sv
hdl/mpeg_ps_demultiplexer.sv
hdl/mpd_checker.sv
bench/mpeg_ps_demultiplexer_tb.sv
